### sv/wnc_pkg.sv
package wnc_pkg;

    localparam int SMP_BITS  = 8;
    localparam int WGT_IN    = 16;
    localparam int WA_BITS   = SMP_BITS + WGT_IN;
    localparam int WAA_BITS  = WA_BITS + SMP_BITS;
    localparam int LIN_BITS  = 40;
    localparam int SQR_BITS  = 48;
    localparam int WGT_BITS  = 32;
    localparam int TOL_BITS  = 16;
    localparam int SHF_BITS  = 6;
    localparam int VAR_BITS  = 80;
    localparam int NUM_BITS  = 96;
    localparam int PRD_BITS  = 192;
    localparam int MY_BITS   = 96;
    localparam int Q_BITS    = 14;
    localparam int KSQ_BITS  = 2 * Q_BITS;
    localparam int NUM_SHIFT = 14;
    localparam int VAL_BITS  = 16;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [Q_BITS-1:0]   ONE_Q13   = Q_BITS'(8192);
    localparam logic [VAL_BITS-1:0] ONE_VAL   = VAL_BITS'(8192);
    localparam logic [SHF_BITS-1:0] SHIFT_RST = SHF_BITS'(20);

    localparam logic [CFG_ADDR_BITS-1:0] REG_ABS_TOL   = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_REL_SHIFT = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PAYOFF    = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_WEIGHT = 3'd1,
        ST_FLAT      = 3'd2,
        ST_UNSTABLE  = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ACCUM,
        OP_WSQ_A,
        OP_SQ_A,
        OP_LIM_A,
        OP_VAR_A,
        OP_WSQ_B,
        OP_SQ_B,
        OP_LIM_B,
        OP_VAR_B,
        OP_P1,
        OP_P2,
        OP_NUM,
        OP_RHS,
        OP_PROD,
        OP_SEARCH_INIT,
        OP_KSQ,
        OP_TRY,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t     op;
        logic    mul_start;
        logic    mul_store;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic mul_done;
        logic overflow;
        logic w_zero;
        logic va_zero;
        logic vb_zero;
        logic unstable;
        logic search_open;
    } sts_t;

endpackage

### sv/wnc_datapath.sv
module wnc_datapath
    import wnc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [31:0]              s_tdata,
    input  logic                     s_tlast,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    output logic [15:0]              out_data,
    output logic [2:0]               out_user
);

    logic [TOL_BITS-1:0] abs_tol_reg;
    logic [SHF_BITS-1:0] rel_shift_reg;
    logic                payoff_reg;

    logic [SMP_BITS-1:0] a_reg, b_reg;
    logic [WGT_IN-1:0]   w_reg;
    logic [WA_BITS-1:0]  wa_reg, wb_reg;
    logic                last_reg;

    logic [LIN_BITS-1:0] acc_a_reg, acc_b_reg;
    logic [SQR_BITS-1:0] acc_aa_reg, acc_bb_reg, acc_ab_reg;
    logic [WGT_BITS-1:0] acc_w_reg;
    logic                ovf_reg;

    logic [PRD_BITS-1:0] mx_reg, mp_reg;
    logic [MY_BITS-1:0]  my_reg;
    logic                busy_reg;

    logic [VAR_BITS-1:0] t0_reg, t1_reg, tlim_reg, va_reg, vb_reg;
    logic                ua_reg, ub_reg, neg_reg;
    logic [NUM_BITS-1:0] num_reg;
    logic [PRD_BITS-1:0] rhs_reg, prod_reg;
    logic [Q_BITS-1:0]   lo_reg, hi_reg, mid_reg;
    logic [KSQ_BITS-1:0] ksq_reg;

    logic [VAL_BITS-1:0] val_reg;
    status_t             status_reg;

    logic [PRD_BITS-1:0] mx_next;
    logic [MY_BITS-1:0]  my_next;

    logic [LIN_BITS:0]   sum_a, sum_b;
    logic [SQR_BITS:0]   sum_aa, sum_bb, sum_ab;
    logic [WGT_BITS:0]   sum_w_full;
    logic [WAA_BITS-1:0] waa, wbb, wab;

    logic [VAR_BITS-1:0] var_val, sq_shifted;
    logic [VAR_BITS:0]   var_lim;
    logic                var_low;
    logic [VAR_BITS-1:0] diff;
    logic [Q_BITS:0]     mid_sum;
    logic [Q_BITS:0]     k_wide;
    logic [Q_BITS-1:0]   k_val;
    logic [VAL_BITS-1:0] mag, signed_val, emit_val;

    always_comb begin
        mx_next = '0;
        my_next = '0;
        unique case (cmd.op)
            OP_WSQ_A: begin
                mx_next = PRD_BITS'(acc_aa_reg);
                my_next = MY_BITS'(acc_w_reg);
            end
            OP_SQ_A: begin
                mx_next = PRD_BITS'(acc_a_reg);
                my_next = MY_BITS'(acc_a_reg);
            end
            OP_LIM_A, OP_LIM_B: begin
                mx_next = PRD_BITS'(abs_tol_reg);
                my_next = MY_BITS'(acc_w_reg);
            end
            OP_WSQ_B: begin
                mx_next = PRD_BITS'(acc_bb_reg);
                my_next = MY_BITS'(acc_w_reg);
            end
            OP_SQ_B: begin
                mx_next = PRD_BITS'(acc_b_reg);
                my_next = MY_BITS'(acc_b_reg);
            end
            OP_P1: begin
                mx_next = PRD_BITS'(acc_ab_reg);
                my_next = MY_BITS'(acc_w_reg);
            end
            OP_P2: begin
                mx_next = PRD_BITS'(acc_a_reg);
                my_next = MY_BITS'(acc_b_reg);
            end
            OP_RHS: begin
                mx_next = PRD_BITS'(num_reg);
                my_next = num_reg;
            end
            OP_PROD: begin
                mx_next = PRD_BITS'(va_reg);
                my_next = MY_BITS'(vb_reg);
            end
            OP_TRY: begin
                mx_next = prod_reg;
                my_next = MY_BITS'(ksq_reg);
            end
            default: begin
                mx_next = '0;
                my_next = '0;
            end
        endcase
    end

    always_comb begin
        waa        = wa_reg * WAA_BITS'(a_reg);
        wbb        = wb_reg * WAA_BITS'(b_reg);
        wab        = wa_reg * WAA_BITS'(b_reg);
        sum_a      = {1'b0, acc_a_reg} + (LIN_BITS+1)'(wa_reg);
        sum_b      = {1'b0, acc_b_reg} + (LIN_BITS+1)'(wb_reg);
        sum_aa     = {1'b0, acc_aa_reg} + (SQR_BITS+1)'(waa);
        sum_bb     = {1'b0, acc_bb_reg} + (SQR_BITS+1)'(wbb);
        sum_ab     = {1'b0, acc_ab_reg} + (SQR_BITS+1)'(wab);
        sum_w_full = {1'b0, acc_w_reg} + (WGT_BITS+1)'(w_reg);
    end

    always_comb begin
        var_val    = (t0_reg >= t1_reg) ? (t0_reg - t1_reg) : '0;
        sq_shifted = t1_reg >> rel_shift_reg;
        var_lim    = {1'b0, tlim_reg} + {1'b0, sq_shifted};
        var_low    = {1'b0, var_val} < var_lim;
        diff       = (t0_reg < t1_reg) ? (t1_reg - t0_reg) : (t0_reg - t1_reg);
        mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg} + (Q_BITS+1)'(1);
        k_wide     = {mid_sum[Q_BITS:1], 1'b0} - (Q_BITS+1)'(1);
        k_val      = k_wide[Q_BITS-1:0];
        mag        = VAL_BITS'(lo_reg);
        signed_val = neg_reg ? (VAL_BITS'(0) - mag) : mag;
        emit_val   = (cmd.status == ST_OK) ? signed_val : '0;
        if (payoff_reg && (cmd.status != ST_NO_WEIGHT)) begin
            emit_val = emit_val + ONE_VAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abs_tol_reg   <= '0;
            rel_shift_reg <= SHIFT_RST;
            payoff_reg    <= 1'b0;
            acc_a_reg     <= '0;
            acc_b_reg     <= '0;
            acc_aa_reg    <= '0;
            acc_bb_reg    <= '0;
            acc_ab_reg    <= '0;
            acc_w_reg     <= '0;
            ovf_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            last_reg      <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
        end else begin
            if (cfg_we) begin
                priority case (cfg_addr)
                    REG_ABS_TOL:   abs_tol_reg   <= cfg_wdata[TOL_BITS-1:0];
                    REG_REL_SHIFT: rel_shift_reg <= cfg_wdata[SHF_BITS-1:0];
                    REG_PAYOFF:    payoff_reg    <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (cmd.mul_start) begin
                mx_reg   <= mx_next;
                my_reg   <= my_next;
                mp_reg   <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (my_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    if (my_reg[0]) begin
                        mp_reg <= mp_reg + mx_reg;
                    end
                    mx_reg <= mx_reg << 1;
                    my_reg <= my_reg >> 1;
                end
            end

            unique case (cmd.op)
                OP_LOAD: begin
                    a_reg    <= s_tdata[7:0];
                    b_reg    <= s_tdata[15:8];
                    w_reg    <= s_tdata[31:16];
                    wa_reg   <= s_tdata[31:16] * WA_BITS'(s_tdata[7:0]);
                    wb_reg   <= s_tdata[31:16] * WA_BITS'(s_tdata[15:8]);
                    last_reg <= s_tlast;
                end
                OP_ACCUM: begin
                    acc_a_reg  <= sum_a[LIN_BITS] ? '1 : sum_a[LIN_BITS-1:0];
                    acc_b_reg  <= sum_b[LIN_BITS] ? '1 : sum_b[LIN_BITS-1:0];
                    acc_aa_reg <= sum_aa[SQR_BITS] ? '1 : sum_aa[SQR_BITS-1:0];
                    acc_bb_reg <= sum_bb[SQR_BITS] ? '1 : sum_bb[SQR_BITS-1:0];
                    acc_ab_reg <= sum_ab[SQR_BITS] ? '1 : sum_ab[SQR_BITS-1:0];
                    acc_w_reg  <= (sum_w_full[WGT_BITS]) ? '1 : sum_w_full[WGT_BITS-1:0];
                    if (sum_a[LIN_BITS] || sum_b[LIN_BITS] || sum_aa[SQR_BITS] ||
                        sum_bb[SQR_BITS] || sum_ab[SQR_BITS] || sum_w_full[WGT_BITS]) begin
                        ovf_reg <= 1'b1;
                    end
                end
                OP_WSQ_A, OP_WSQ_B, OP_P1: begin
                    if (cmd.mul_store) t0_reg <= mp_reg[VAR_BITS-1:0];
                end
                OP_SQ_A, OP_SQ_B, OP_P2: begin
                    if (cmd.mul_store) t1_reg <= mp_reg[VAR_BITS-1:0];
                end
                OP_LIM_A, OP_LIM_B: begin
                    if (cmd.mul_store) tlim_reg <= mp_reg[VAR_BITS-1:0];
                end
                OP_VAR_A: begin
                    va_reg <= var_val;
                    ua_reg <= var_low;
                end
                OP_VAR_B: begin
                    vb_reg <= var_val;
                    ub_reg <= var_low;
                end
                OP_NUM: begin
                    neg_reg <= t0_reg < t1_reg;
                    num_reg <= NUM_BITS'(diff) << NUM_SHIFT;
                end
                OP_RHS: begin
                    if (cmd.mul_store) rhs_reg <= mp_reg;
                end
                OP_PROD: begin
                    if (cmd.mul_store) prod_reg <= mp_reg;
                end
                OP_SEARCH_INIT: begin
                    lo_reg <= '0;
                    hi_reg <= ONE_Q13;
                end
                OP_KSQ: begin
                    mid_reg <= mid_sum[Q_BITS:1];
                    ksq_reg <= KSQ_BITS'(k_val) * KSQ_BITS'(k_val);
                end
                OP_TRY: begin
                    if (cmd.mul_store) begin
                        if (mp_reg <= rhs_reg) lo_reg <= mid_reg;
                        else hi_reg <= mid_reg - Q_BITS'(1);
                    end
                end
                OP_EMIT: begin
                    val_reg    <= emit_val;
                    status_reg <= cmd.status;
                    acc_a_reg  <= '0;
                    acc_b_reg  <= '0;
                    acc_aa_reg <= '0;
                    acc_bb_reg <= '0;
                    acc_ab_reg <= '0;
                    acc_w_reg  <= '0;
                    ovf_reg    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign sts.last        = last_reg;
    assign sts.mul_done    = busy_reg && (my_reg == '0);
    assign sts.overflow    = ovf_reg;
    assign sts.w_zero      = (acc_w_reg == '0);
    assign sts.va_zero     = (va_reg == '0);
    assign sts.vb_zero     = (vb_reg == '0);
    assign sts.unstable    = ua_reg || ub_reg;
    assign sts.search_open = lo_reg < hi_reg;

    assign out_data = val_reg;
    assign out_user = status_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |-> !busy_reg)
        else $error("multiplier started while busy");
    a_search_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (lo_reg <= hi_reg) && (hi_reg <= ONE_Q13))
        else $error("search bounds crossed");
`endif

endmodule

### sv/wnc_ctrl.sv
module wnc_ctrl
    import wnc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_ACCUM, S_CLOSE,
        S_WSQ_A, S_SQ_A, S_LIM_A, S_VAR_A,
        S_WSQ_B, S_SQ_B, S_LIM_B, S_VAR_B,
        S_CHECK, S_P1, S_P2, S_NUM, S_RHS, S_PROD,
        S_INIT, S_LOOP, S_KSQ, S_TRY, S_EMIT
    } state_t;

    state_t  state_reg;
    logic    phase_reg;
    logic    m_tvalid_reg;
    status_t status_reg;
    logic    is_mul;
    state_t  mul_after;
    logic    out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.op        = OP_NONE;
        cmd.status    = status_reg;
        is_mul        = 1'b0;
        mul_after     = S_IDLE;
        unique case (state_reg)
            S_IDLE:   if (s_tvalid) cmd.op = OP_LOAD;
            S_ACCUM:  cmd.op = OP_ACCUM;
            S_CLOSE:  cmd.op = OP_NONE;
            S_WSQ_A:  begin cmd.op = OP_WSQ_A; is_mul = 1'b1; mul_after = S_SQ_A;  end
            S_SQ_A:   begin cmd.op = OP_SQ_A;  is_mul = 1'b1; mul_after = S_LIM_A; end
            S_LIM_A:  begin cmd.op = OP_LIM_A; is_mul = 1'b1; mul_after = S_VAR_A; end
            S_VAR_A:  cmd.op = OP_VAR_A;
            S_WSQ_B:  begin cmd.op = OP_WSQ_B; is_mul = 1'b1; mul_after = S_SQ_B;  end
            S_SQ_B:   begin cmd.op = OP_SQ_B;  is_mul = 1'b1; mul_after = S_LIM_B; end
            S_LIM_B:  begin cmd.op = OP_LIM_B; is_mul = 1'b1; mul_after = S_VAR_B; end
            S_VAR_B:  cmd.op = OP_VAR_B;
            S_CHECK:  cmd.op = OP_NONE;
            S_P1:     begin cmd.op = OP_P1;   is_mul = 1'b1; mul_after = S_P2;   end
            S_P2:     begin cmd.op = OP_P2;   is_mul = 1'b1; mul_after = S_NUM;  end
            S_NUM:    cmd.op = OP_NUM;
            S_RHS:    begin cmd.op = OP_RHS;  is_mul = 1'b1; mul_after = S_PROD; end
            S_PROD:   begin cmd.op = OP_PROD; is_mul = 1'b1; mul_after = S_INIT; end
            S_INIT:   cmd.op = OP_SEARCH_INIT;
            S_LOOP:   cmd.op = OP_NONE;
            S_KSQ:    cmd.op = OP_KSQ;
            S_TRY:    begin cmd.op = OP_TRY;  is_mul = 1'b1; mul_after = S_LOOP; end
            S_EMIT:   if (out_free) cmd.op = OP_EMIT;
            default:  cmd.op = OP_NONE;
        endcase
        cmd.mul_start = is_mul && !phase_reg;
        cmd.mul_store = is_mul && phase_reg && sts.mul_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            status_reg   <= ST_OK;
        end else begin
            if ((state_reg == S_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (is_mul) begin
                if (!phase_reg) begin
                    phase_reg <= 1'b1;
                end else if (sts.mul_done) begin
                    phase_reg <= 1'b0;
                    state_reg <= mul_after;
                end
            end else begin
                unique case (state_reg)
                    S_IDLE:  if (s_tvalid) state_reg <= S_ACCUM;
                    S_ACCUM: state_reg <= sts.last ? S_CLOSE : S_IDLE;
                    S_CLOSE: begin
                        priority if (sts.overflow) begin
                            status_reg <= ST_SATURATED;
                            state_reg  <= S_EMIT;
                        end else if (sts.w_zero) begin
                            status_reg <= ST_NO_WEIGHT;
                            state_reg  <= S_EMIT;
                        end else begin
                            state_reg  <= S_WSQ_A;
                        end
                    end
                    S_VAR_A: state_reg <= S_WSQ_B;
                    S_VAR_B: state_reg <= S_CHECK;
                    S_CHECK: begin
                        priority if (sts.va_zero || sts.vb_zero) begin
                            status_reg <= ST_FLAT;
                            state_reg  <= S_EMIT;
                        end else if (sts.unstable) begin
                            status_reg <= ST_UNSTABLE;
                            state_reg  <= S_EMIT;
                        end else begin
                            status_reg <= ST_OK;
                            state_reg  <= S_P1;
                        end
                    end
                    S_NUM:   state_reg <= S_RHS;
                    S_INIT:  state_reg <= S_LOOP;
                    S_LOOP:  state_reg <= sts.search_open ? S_KSQ : S_EMIT;
                    S_KSQ:   state_reg <= S_TRY;
                    S_EMIT: begin
                        if (out_free) begin
                            state_reg <= S_IDLE;
                        end
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

`ifndef SYNTH
    a_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.mul_done |-> phase_reg)
        else $error("multiplier result with no request outstanding");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT) |-> (!m_tvalid_reg || m_tready))
        else $error("result written over a pending transfer");
    a_accept_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (!phase_reg && !sts.mul_done))
        else $error("input taken during closing arithmetic");
`endif

endmodule

### sv/weighted_ncc_accumulator.sv
// weighted normalised cross-correlation accumulator
// s_ channel: one weighted pixel pair per transfer, s_tlast closes the window.
// cfg port: cfg_we/cfg_addr/cfg_wdata write abs_tolerance (0), rel_tolerance_shift
// (1) and payoff_mode (2); write only while the block is idle.
// m_ channel: one result per window, ncc_value in m_tdata, status in m_tuser.
// each pair first registers its weight products, then does the saturating
// accumulate; no new pair is taken before both are done. after the last pair
// the window is closed by one shift-and-add multiplier that retires one
// multiplier bit a cycle: first the variance products, then the cross and
// energy products, then up to 14 binary-search steps for the Q3.13 value;
// saturation and no weight windows go straight to the result, flat and unstable
// windows follow the variance products.
// the result sits in an output register; a new window is accepted while it
// waits, and only the next result waits for m_tready.
// reset (aresetn low, synchronous) clears sums, flags and the output valid and
// restores the register defaults.
module weighted_ncc_accumulator
    import wnc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [31:0]              s_tdata,   // sample_a, sample_b, weight
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [15:0]              m_tdata,   // ncc_value
    output logic [2:0]               m_tuser,   // status
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    wnc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wnc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule
